[rtl/wildcard_byte_pattern_search_assert.svh]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search: assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WBPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wbps: same-cycle check failed");

// next-cycle implication
`define WBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wbps: next-cycle check failed");

`else

`define WBPS_ASSERT_SAME(lbl, ante, cons)
`define WBPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search package
// Shared constants, register indexes and cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int unsigned PatternMax = 48;
  localparam int unsigned WordBytes  = 8;
  localparam int unsigned NumWords   = PatternMax / WordBytes;
  localparam int unsigned LenW       = 6;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  localparam logic [7:0] WildcardByte = 8'h2A;
  localparam logic [LenW-1:0] LenMax  = LenW'(PatternMax);

  typedef enum logic [CfgIdxW-1:0] {
    CfgLength = 3'd0,
    CfgBase   = 3'd1,
    CfgPat0   = 3'd2,
    CfgPat1   = 3'd3,
    CfgPat2   = 3'd4,
    CfgPat3   = 3'd5,
    CfgPat4   = 3'd6,
    CfgPat5   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic advance;  // shift the chain by one byte
    logic flush;    // window ends: clear all match bits
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/wbps_if.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search channels
// Valid/ready interfaces for the byte input, the result output and config.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

interface wbps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/wbps_cell.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search cell
// One shift-and stage: holds one partial-match bit and one signature byte test.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wbps_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]          data_i,
  input  wire logic [7:0]          pat_i,
  input  wire logic                en_i,
  input  wire logic                prev_i,
  output logic                     nxt_o,
  output logic                     bit_o
);
  import wbps_pkg::*;

  logic bit_q, bit_d;
  logic hit;

  assign hit   = (pat_i == WildcardByte) || (pat_i == data_i);
  assign nxt_o = prev_i & hit & en_i;

  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.flush) begin
      bit_d = 1'b0;
    end else if (ctrl_i.advance) begin
      bit_d = nxt_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

`default_nettype wire

[rtl/wildcard_byte_pattern_search.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search
// Streams a byte window through a chain of shift-and cells and reports the
// address of the first signature match, or not found at the window end.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while the input is not stalled, with no gaps
// between windows. All 48 cells compare the incoming byte against their
// signature byte and shift their match bit in the same cycle, so the chain
// keeps up with that rate. A result (match or not found) is loaded into an
// output register in the cycle after the transfer of the byte that completed
// the match or ended the window; the input stalls only while that register
// holds a result and the sink is not ready to take it.
// Signature byte 0x2A matches any byte. Config writes are always accepted
// and are meant to happen while the block is idle.
`default_nettype none

`include "wildcard_byte_pattern_search_assert.svh"

module wildcard_byte_pattern_search (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wbps_in_if.sink     in_i,
  wbps_out_if.source  out_o,
  wbps_cfg_if.sink    cfg_i
);
  import wbps_pkg::*;

  // configuration registers
  logic [LenW-1:0]     len_q;
  logic [AddrW-1:0]    base_q;
  logic [CfgDataW-1:0] pat_q [NumWords];

  // window state
  logic [AddrW-1:0] pos_q, pos_d;
  logic             reported_q, reported_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             found_q;
  logic [AddrW-1:0] addr_q;

  logic             in_fire, len_zero, hit, report_hit, load_res;
  logic [LenW-1:0]  len_eff, len_m1;
  logic [AddrW-1:0] start_off;
  cell_ctrl_t       ctrl;
  logic [PatternMax-1:0] nxt_bits, bits, en;

  // -- config port ----------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenW'(1);
      base_q <= '0;
      for (int w = 0; w < NumWords; w++) begin
        pat_q[w] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgLength: len_q  <= cfg_i.data[LenW-1:0];
        CfgBase:   base_q <= cfg_i.data[AddrW-1:0];
        CfgPat0, CfgPat1, CfgPat2, CfgPat3, CfgPat4, CfgPat5: begin
          pat_q[cfg_i.index - CfgIdxW'(CfgPat0)] <= cfg_i.data;
        end
        default: ;
      endcase
    end
  end

  // -- cell chain -----------------------------------------------------------
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign len_eff  = (len_q > LenMax) ? LenMax : len_q;
  assign len_zero = (len_eff == '0);

  assign ctrl.advance = in_fire && !len_zero;
  assign ctrl.flush   = in_fire && in_i.last_byte;

  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    assign en[k] = (LenW'(k) < len_eff);

    wbps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .data_i (in_i.data_byte),
      .pat_i  (pat_q[k / WordBytes][(k % WordBytes) * 8 +: 8]),
      .en_i   (en[k]),
      .prev_i ((k == 0) ? 1'b1 : bits[(k == 0) ? 0 : k - 1]),
      .nxt_o  (nxt_bits[k]),
      .bit_o  (bits[k])
    );
  end

  // -- match detection ------------------------------------------------------
  assign len_m1     = len_zero ? '0 : len_eff - LenW'(1);
  assign hit        = len_zero || nxt_bits[len_m1];
  assign report_hit = hit && !reported_q;
  assign load_res   = in_fire && (report_hit || (in_i.last_byte && !reported_q));
  assign start_off  = pos_q - AddrW'(len_m1);

  always_comb begin
    pos_d      = pos_q;
    reported_d = reported_q;
    if (in_fire) begin
      if (in_i.last_byte) begin
        pos_d      = '0;
        reported_d = 1'b0;
      end else begin
        pos_d      = pos_q + AddrW'(1);
        reported_d = reported_q || hit;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      found_q <= report_hit;
      addr_q  <= report_hit ? base_q + start_off : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.found         = found_q;
  assign out_o.match_address = addr_q;

  // -- checks ---------------------------------------------------------------
  `WBPS_ASSERT_SAME(a_one_result_per_window, in_fire && reported_q, !load_res)
  `WBPS_ASSERT_NEXT(a_window_clears, in_fire && in_i.last_byte,
                    pos_q == '0 && !reported_q && bits == '0)
  `WBPS_ASSERT_SAME(a_miss_addr_zero, out_valid_q && !found_q, addr_q == '0)
  `WBPS_ASSERT_SAME(a_no_bits_past_len, !len_zero, (nxt_bits & ~en) == '0)

endmodule

`default_nettype wire

[dv/signature_scan_checker.sv]
// ----------------------------------------------------------------------------
// Signature scan checker
// Watches the config, byte and report channels of the pattern search block,
// tracks the signature and window state on its own, and compares every
// report against the oldest predicted one.
// ----------------------------------------------------------------------------
module signature_scan_checker
  import wbps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wbps_in_if          byte_mon,
  wbps_out_if         report_mon,
  wbps_cfg_if         cfg_mon,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              found;
    logic [AddrW-1:0]  addr;
  } scan_report_t;

  // signature registers as last written
  logic [LenW-1:0]     sig_len;
  logic [AddrW-1:0]    search_base;
  logic [CfgDataW-1:0] sig_words [NumWords];

  // window state
  logic [PatternMax-1:0] partials;
  logic [AddrW-1:0]      position;
  logic                  reported;

  scan_report_t expected_reports [$];

  initial mismatches_o = 0;

  task automatic scan_byte(input logic [7:0] data, input logic last);
    logic [LenW-1:0]       len;
    logic [PatternMax-1:0] byte_hits;
    logic [7:0]            sig_b;
    logic                  hit;
    logic [AddrW-1:0]      start;
    len = (sig_len > LenMax) ? LenMax : sig_len;
    hit = 1'b0;
    start = '0;
    if (len == '0) begin
      // empty signature matches right where it stands
      hit = 1'b1;
      start = position;
    end else begin
      byte_hits = '0;
      for (int k = 0; k < PatternMax; k++) begin
        sig_b = sig_words[k / WordBytes][(k % WordBytes) * 8 +: 8];
        if (k < len && (sig_b == WildcardByte || sig_b == data)) byte_hits[k] = 1'b1;
      end
      partials = ((partials << 1) | PatternMax'(1)) & byte_hits;
      if (partials[len - 1'b1]) begin
        hit = 1'b1;
        start = position - AddrW'(len) + 1'b1;
      end
    end
    if (hit && !reported) begin
      expected_reports.push_back('{found: 1'b1, addr: search_base + start});
      reported = 1'b1;
    end
    if (last) begin
      if (!reported) expected_reports.push_back('{found: 1'b0, addr: '0});
      partials = '0;
      position = '0;
      reported = 1'b0;
    end else begin
      position = position + 1'b1;
    end
  endtask

  task automatic check_report(input scan_report_t got);
    scan_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected report found=%0b addr=%h", $time, got.found, got.addr);
      mismatches_o++;
    end else begin
      want = expected_reports.pop_front();
      if (got.found != want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
        mismatches_o++;
      end
      if (got.addr != want.addr) begin
        $display("%0t: match_address expected %h actual %h", $time, want.addr, got.addr);
        mismatches_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_len = LenW'(1);
      search_base = '0;
      for (int w = 0; w < NumWords; w++) sig_words[w] = '0;
      partials = '0;
      position = '0;
      reported = 1'b0;
      expected_reports.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          CfgLength: sig_len = cfg_mon.data[LenW-1:0];
          CfgBase:   search_base = cfg_mon.data[AddrW-1:0];
          default:   sig_words[int'(cfg_mon.index) - int'(CfgPat0)] = cfg_mon.data;
        endcase
      end
      // predict first so a same-edge report still finds its entry
      if (byte_mon.valid && byte_mon.ready) scan_byte(byte_mon.data_byte, byte_mon.last_byte);
      if (report_mon.valid && report_mon.ready) begin
        check_report('{found: report_mon.found, addr: report_mon.match_address});
      end
    end
    pending_o = expected_reports.size();
  end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern search testbench
// Directed windows for wildcards, address wrap, late and repeated matches,
// empty signature and mid-window reprogramming, then random signatures with
// embedded, broken and partial copies under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned ByteTarget = 1300;

  logic clk_i;
  logic rst_ni;

  wbps_in_if  byte_ch ();
  wbps_out_if report_ch ();
  wbps_cfg_if cfg_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles;
  int unsigned bytes_sent;
  bit          calm;

  // stimulus copy of the signature, used to plant matches in windows
  logic [7:0]  stim_sig [PatternMax];
  int unsigned eff_len;

  wildcard_byte_pattern_search uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (report_ch),
    .cfg_i  (cfg_ch)
  );

  signature_scan_checker scan_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_mon     (byte_ch),
    .report_mon   (report_ch),
    .cfg_mon      (cfg_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    report_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    while (!calm && $urandom_range(0, 99) < 9) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= value;
    byte_ch.last_byte <= last;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop the byte stream, drain reports, then allow for a result-less byte
  task automatic quiesce();
    byte_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // junk in the unused upper bits of length and base must be ignored
  task automatic program_signature(input logic [LenW-1:0] len, input logic [31:0] base);
    logic [63:0] word;
    write_reg(CfgLength, {$urandom, 26'($urandom), len});
    write_reg(CfgBase, {$urandom, base});
    for (int w = 0; w < NumWords; w++) begin
      for (int b = 0; b < WordBytes; b++) word[b * 8 +: 8] = stim_sig[w * WordBytes + b];
      write_reg(cfg_idx_e'(int'(CfgPat0) + w), word);
    end
    eff_len = (len > LenMax) ? PatternMax : len;
  endtask

  task automatic send_window();
    logic [7:0]  win [80];
    int unsigned wlen;
    int unsigned at;
    if (eff_len == 0) wlen = $urandom_range(1, 6);
    else if ($urandom_range(0, 3) == 0) wlen = $urandom_range(1, eff_len + 16);
    else wlen = $urandom_range(eff_len, eff_len + 6);
    // background leans on signature bytes to build partial matches
    for (int i = 0; i < wlen; i++) begin
      if (eff_len > 0 && $urandom_range(0, 1) == 1) win[i] = stim_sig[$urandom_range(0, eff_len - 1)];
      else win[i] = 8'($urandom);
    end
    if (eff_len > 0 && wlen >= eff_len && $urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(1, 2)) begin
        at = $urandom_range(0, wlen - eff_len);
        for (int k = 0; k < eff_len; k++) begin
          win[at + k] = (stim_sig[k] == WildcardByte) ? 8'($urandom) : stim_sig[k];
        end
        if ($urandom_range(0, 4) == 0) begin
          win[at + $urandom_range(0, eff_len - 1)] ^= 8'($urandom_range(1, 255));
        end
      end
    end
    for (int i = 0; i < wlen; i++) send_byte(win[i], i == wlen - 1);
  endtask

  task automatic random_phase();
    logic [LenW-1:0] len;
    logic [31:0]     base;
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = LenW'(PatternMax);
      2:       len = $urandom_range(0, 1) ? '1 : LenW'($urandom_range(PatternMax + 1, 62));
      3:       len = LenW'(1);
      default: len = LenW'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1;
      default: base = $urandom;
    endcase
    for (int k = 0; k < PatternMax; k++) begin
      stim_sig[k] = ($urandom_range(0, 4) == 0) ? WildcardByte : 8'($urandom);
    end
    calm = (bytes_sent >= 600 && bytes_sent < 900);
    quiesce();
    program_signature(len, base);
    repeat ($urandom_range(3, 8)) send_window();
  endtask

  initial begin
    rst_ni = 1'b0;
    calm = 1'b0;
    eff_len = 1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CfgLength;
    cfg_ch.data = '0;
    report_ch.ready = 1'b0;
    for (int k = 0; k < PatternMax; k++) stim_sig[k] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset signature: one byte 0x00 at base 0
    send_byte(8'hAB, 1'b0);
    send_byte(8'h00, 1'b1);
    quiesce();

    // "A?BC" with a base just below the top of the address space
    stim_sig[0] = 8'h41;
    stim_sig[1] = WildcardByte;
    stim_sig[2] = 8'h42;
    stim_sig[3] = 8'h43;
    program_signature(LenW'(4), 32'hFFFF_FFFE);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    // second copy and the window end stay silent
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h11, 1'b1);
    // window shorter than the signature
    send_byte(8'h41, 1'b0);
    send_byte(WildcardByte, 1'b1);
    // match completing on the last byte
    send_byte(8'h41, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b1);
    quiesce();

    // empty signature
    write_reg(CfgLength, '0);
    write_reg(CfgBase, '0);
    send_byte(8'h7E, 1'b1);
    quiesce();

    // reprogram mid-window: partial bits from the old signature carry over
    for (int k = 0; k < PatternMax; k++) stim_sig[k] = '0;
    stim_sig[0] = 8'h58;
    stim_sig[1] = 8'h59;
    stim_sig[2] = 8'h5A;
    program_signature(LenW'(3), 32'h1234_5678);
    send_byte(8'h58, 1'b0);
    send_byte(8'h59, 1'b0);
    quiesce();
    write_reg(CfgPat0, 64'h0057_5958);
    write_reg(CfgBase, 64'h8000_0000);
    send_byte(8'h57, 1'b0);
    send_byte(8'h00, 1'b1);

    while (bytes_sent < ByteTarget) random_phase();

    calm = 1'b0;
    quiesce();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
